### src/nt2j_pkg.sv
// ============================================================================
// nt2j_pkg: shared types of the number text normalizer
// Result entry and result group formats passed between the step logic and
// the output burst buffer.
// ============================================================================
package nt2j_pkg;

  // Number of result entries that one input character can produce.
  localparam int unsigned NT2J_BURST = 4;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_text;
    logic       failed;
  } nt2j_entry_t;

  // All results caused by one input character, entry 0 goes out first.
  typedef struct packed {
    logic [2:0]                       cnt;
    nt2j_entry_t [NT2J_BURST-1:0]     ents;
  } nt2j_group_t;

endpackage

### src/nt2j_core.sv
// ============================================================================
// nt2j_core: grammar state and per-character step logic
// Holds the number grammar state and turns one character into a group of up
// to four result entries in a single combinational pass.
// ============================================================================
module nt2j_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [7:0]           in_char,
  input  logic                 in_last,
  input  logic                 burst_free,
  output logic                 fire,
  output logic                 load,
  output nt2j_pkg::nt2j_group_t grp
);
  import nt2j_pkg::*;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_F     = 8'h66;

  typedef enum logic [3:0] {
    PH_START, PH_SIGNED, PH_I1, PH_I2, PH_ZEROS, PH_DOTQ, PH_DOT1, PH_INT,
    PH_DOT2, PH_FRAC, PH_ECHK, PH_AFTER_E, PH_ESIGN, PH_EXP, PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   dot_seen;
    logic   fail_flag;
    logic   wrote_any;
  } state_t;

  typedef struct packed {
    state_t          st;
    logic [2:0]      cnt;
    logic [3:0][7:0] chars;
  } work_t;

  typedef struct packed {
    state_t      st;
    nt2j_group_t grp;
  } step_t;

  localparam state_t ST_RESET = '{phase: PH_START, dot_seen: 1'b0,
                                  fail_flag: 1'b0, wrote_any: 1'b0};

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic work_t push(work_t w, logic [7:0] ch);
    work_t r;
    r = w;
    if (w.cnt < 3'd4) begin
      r.chars[w.cnt[1:0]] = ch;
      r.cnt = w.cnt + 3'd1;
    end
    r.st.wrote_any = 1'b1;
    return r;
  endfunction

  // Stop emitting; a text that produced nothing so far has failed.
  function automatic work_t halt(work_t w);
    work_t r;
    r = w;
    r.st.phase = PH_DONE;
    if (!w.st.wrote_any) r.st.fail_flag = 1'b1;
    return r;
  endfunction

  function automatic step_t step(state_t s, logic [7:0] c, logic last);
    work_t w;
    logic  stop;
    logic  bad;
    step_t r;
    w.st    = s;
    w.cnt   = 3'd0;
    w.chars = '0;
    stop    = 1'b0;
    bad     = 1'b0;
    // A character may fall through several grammar phases before it is used.
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        case (w.st.phase)
          PH_START: begin
            if (c == CH_MINUS) begin
              w = push(w, c);
              stop = 1'b1;
            end
            w.st.phase = PH_SIGNED;
          end
          PH_SIGNED: begin
            if (c == CH_I) begin
              w.st.phase = PH_I1;
              stop = 1'b1;
            end else if (c == CH_0) begin
              w.st.phase = PH_ZEROS;
              stop = 1'b1;
            end else begin
              w.st.phase = PH_DOTQ;
            end
          end
          PH_I1: begin
            if (c == CH_N) begin
              w.st.phase = PH_I2;
            end else begin
              w.st.fail_flag = 1'b1;
              w.st.phase = PH_DONE;
            end
            stop = 1'b1;
          end
          PH_I2: begin
            if (c == CH_F) begin
              w = push(w, CH_1);
              w = push(w, CH_E_LO);
              w = push(w, CH_9);
              w = push(w, CH_9);
            end else begin
              w.st.fail_flag = 1'b1;
            end
            w.st.phase = PH_DONE;
            stop = 1'b1;
          end
          PH_ZEROS: begin
            if (c == CH_0) stop = 1'b1;
            else w.st.phase = PH_DOTQ;
          end
          PH_DOTQ: begin
            if (c == CH_DOT) begin
              w = push(w, CH_0);
              w = push(w, CH_DOT);
              w.st.dot_seen = 1'b1;
              w.st.phase = PH_DOT1;
              stop = 1'b1;
            end else begin
              w.st.phase = PH_INT;
            end
          end
          PH_DOT1: begin
            if (!is_digit(c)) w = push(w, CH_0);
            w.st.phase = PH_INT;
          end
          PH_INT: begin
            if (is_digit(c)) begin
              w = push(w, c);
              stop = 1'b1;
            end else if (c == CH_DOT) begin
              if (w.st.dot_seen) begin
                w = halt(w);
              end else begin
                w = push(w, c);
                w.st.phase = PH_DOT2;
              end
              stop = 1'b1;
            end else begin
              w.st.phase = PH_ECHK;
            end
          end
          PH_DOT2: begin
            if (is_digit(c)) begin
              w = push(w, c);
              w.st.phase = PH_FRAC;
              stop = 1'b1;
            end else begin
              w = push(w, CH_0);
              w.st.phase = PH_ECHK;
            end
          end
          PH_FRAC: begin
            if (is_digit(c)) begin
              w = push(w, c);
              stop = 1'b1;
            end else begin
              w.st.phase = PH_ECHK;
            end
          end
          PH_ECHK: begin
            if (c == CH_E_LO || c == CH_E_UP) begin
              w = push(w, c);
              w.st.phase = PH_AFTER_E;
            end else begin
              w = halt(w);
            end
            stop = 1'b1;
          end
          PH_AFTER_E: begin
            if (c == CH_MINUS || c == CH_PLUS) begin
              w = push(w, c);
              stop = 1'b1;
            end
            w.st.phase = PH_ESIGN;
          end
          PH_ESIGN: begin
            if (is_digit(c)) begin
              w = push(w, c);
              w.st.phase = PH_EXP;
            end else begin
              w = push(w, CH_0);
              w = halt(w);
            end
            stop = 1'b1;
          end
          PH_EXP: begin
            if (is_digit(c)) w = push(w, c);
            else w = halt(w);
            stop = 1'b1;
          end
          default: begin
            w.st.phase = PH_DONE;
            stop = 1'b1;
          end
        endcase
      end
    end

    // Closing the text: patch unfinished forms and settle the status.
    if (last) begin
      case (w.st.phase)
        PH_SIGNED, PH_I1, PH_I2: bad = 1'b1;
        PH_ZEROS, PH_DOT1, PH_DOT2, PH_AFTER_E, PH_ESIGN: w = push(w, CH_0);
        default: bad = bad;
      endcase
      if (w.st.fail_flag || !w.st.wrote_any) bad = 1'b1;
    end

    r.grp = '0;
    if (last && (w.cnt == 3'd0)) begin
      r.grp.cnt = 3'd1;
      r.grp.ents[0].end_of_text = 1'b1;
      r.grp.ents[0].failed = bad;
    end else begin
      r.grp.cnt = w.cnt;
      for (int k = 0; k < NT2J_BURST; k++) begin
        r.grp.ents[k].out_char    = w.chars[k];
        r.grp.ents[k].has_char    = (3'(k) < w.cnt);
        r.grp.ents[k].end_of_text = last && (3'(k) == (w.cnt - 3'd1));
        r.grp.ents[k].failed      = last && bad && (3'(k) == (w.cnt - 3'd1));
      end
    end
    r.st = last ? ST_RESET : w.st;
    return r;
  endfunction

  state_t st_r;
  state_t st_nxt;
  step_t  res;

  always_comb begin
    res    = step(st_r, in_char, in_last);
    grp    = res.grp;
    fire   = in_vld && ((res.grp.cnt == 3'd0) || burst_free);
    load   = fire && (res.grp.cnt != 3'd0);
    st_nxt = fire ? res.st : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

### src/nt2j_burst.sv
// ============================================================================
// nt2j_burst: output burst buffer
// Holds the result group of one character and hands it out one entry per
// accepted output request.
// ============================================================================
module nt2j_burst (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  nt2j_pkg::nt2j_group_t grp,
  input  logic                  out_ready,
  output logic                  out_valid,
  output nt2j_pkg::nt2j_entry_t out_ent,
  output logic                  free
);
  import nt2j_pkg::*;

  logic [2:0]                   cnt_r, cnt_nxt;
  logic [1:0]                   idx_r, idx_nxt;
  nt2j_entry_t [NT2J_BURST-1:0] ents_r;
  logic                         take;
  logic                         drain_last;

  assign out_valid  = (cnt_r != 3'd0);
  assign out_ent    = ents_r[idx_r];
  assign take       = out_valid && out_ready;
  assign drain_last = take && (({1'b0, idx_r} + 3'd1) == cnt_r);
  assign free       = !out_valid || drain_last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = grp.cnt;
      idx_nxt = 2'd0;
    end else if (drain_last) begin
      cnt_nxt = 3'd0;
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents_r <= grp.ents;
    end
  end

endmodule

### src/number_text_to_json_normalizer.sv
// ============================================================================
// number_text_to_json_normalizer: numeric text to JSON number
// Streams the characters of a numeric text and re-emits them as a valid JSON
// number, with a status on the last result of each text.
// ============================================================================
//
//  Channel | Direction | tdata            | tuser                     | tlast
//  --------+-----------+------------------+---------------------------+------------
//  in_     | slave     | [7:0] in_char    | (none)                    | final_char
//  out_    | master    | [7:0] out_char   | [0] has_char, [1] failed  | end_of_text
//
// Each accepted character is registered, then stepped through the grammar in
// one combinational pass; its zero to four results land in the burst buffer
// together. Characters that give one result flow at one request per cycle while
// the output is ready; one that gives more stalls the input while the buffer drains.
// Reset (rst_n low, synchronous) returns the grammar to the start of a text
// and empties both the input register and the burst buffer.
// Either side may stall at any time; nothing is lost or repeated.
//
module number_text_to_json_normalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // final_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [0] has_char, [1] failed
  output logic       out_tlast   // end_of_text
);
  import nt2j_pkg::*;

  // Input register: one character request waiting for the step logic.
  logic        in_vld_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;

  logic        fire;
  logic        load;
  logic        burst_free;
  nt2j_group_t grp;
  nt2j_entry_t out_ent;

  // A new request enters when the register is empty or is consumed now.
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Grammar state and the per-character step.
  nt2j_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_vld_r),
    .in_char    (in_char_r),
    .in_last    (in_last_r),
    .burst_free (burst_free),
    .fire       (fire),
    .load       (load),
    .grp        (grp)
  );

  // Result registers, drained one entry per output request.
  nt2j_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (grp),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_ent   (out_ent),
    .free      (burst_free)
  );

  assign out_tdata = out_ent.out_char;
  assign out_tuser = {out_ent.failed, out_ent.has_char};
  assign out_tlast = out_ent.end_of_text;

endmodule

### tb/number_text_to_json_normalizer_test.sv
// ============================================================================
// number_text_to_json_normalizer_test: self-checking bench of the normalizer
// Streams numeric texts into the block one character per request and checks
// every emitted result, in order, against a grammar predictor kept in step
// with the accepted characters. A short table of hand-picked texts comes
// first, then random texts, mostly well-formed numbers with random content.
// ============================================================================
module number_text_to_json_normalizer_test;
  import nt2j_pkg::*;

  // Position in the number grammar while a text streams in.
  typedef enum logic [3:0] {
    S_START,
    S_SIGN,
    S_I1,
    S_I2,
    S_ZEROS,
    S_DOTQ,
    S_DOT1,
    S_INT,
    S_DOT2,
    S_FRAC,
    S_ECHK,
    S_AFTER_E,
    S_ESIGN,
    S_EXP,
    S_DONE
  } num_phase_t;

  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_E_LO  = "e";
  localparam logic [7:0] CH_E_UP  = "E";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_TOP = 8'hFF;

  localparam int unsigned TOTAL_CHARS  = 370;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One row of the directed table. A typed row carries its expected output
  // text and status; the other rows are checked against the predictor.
  typedef struct {
    string text;
    bit    typed;
    string want;
    bit    want_fail;
    bit    status_tail;
  } text_case_t;

  // In the table, '#' stands for the byte 0x00 and '~' for 0xFF, neither of
  // which a string literal can carry.
  localparam int N_DIRECTED = 10;
  text_case_t directed_texts [N_DIRECTED] = '{
    '{"-",     1'b1, "-",    1'b1, 1'b0},  // lone minus
    '{"inf",   1'b1, "1e99", 1'b0, 1'b0},
    '{"ix",    1'b1, "",     1'b1, 1'b0},  // bad i-word
    '{"~",     1'b1, "",     1'b1, 1'b0},  // nothing recognized at all
    '{"0",     1'b1, "0",    1'b0, 1'b0},
    '{"infx",  1'b1, "1e99", 1'b0, 1'b1},  // trailer after inf is ignored
    '{"0e5",   1'b0, "",     1'b0, 1'b0},  // leading zero dropped before 'e'
    '{"..",    1'b0, "",     1'b0, 1'b0},  // second dot after a leading dot
    '{"-.E+#", 1'b0, "",     1'b0, 1'b0},  // bare dot, signed empty exponent
    '{"00.5e", 1'b0, "",     1'b0, 1'b0}   // empty exponent at end of text
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_char
  logic       in_tlast   = 1'b0;   // final_char
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_char
  logic [1:0] out_tuser;           // [0] has_char, [1] failed
  logic       out_tlast;           // end_of_text

  // Predictor state, reset to the start of a text.
  num_phase_t  text_phase  = S_START;
  bit          lead_dot    = 1'b0;
  bit          text_failed = 1'b0;
  bit          any_written = 1'b0;
  nt2j_entry_t step_out[$];

  nt2j_entry_t expected_q[$];
  logic [7:0]  text_q[$];
  int unsigned live_chars = 0;
  int unsigned mismatches = 0;
  bit          send_idle  = 1'b1;

  number_text_to_json_normalizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Grammar predictor
  // ---------------------------------------------------------------------------
  function void put_char(input logic [7:0] c);
    if (step_out.size() < NT2J_BURST) begin
      step_out.push_back('{out_char: c, has_char: 1'b1, end_of_text: 1'b0, failed: 1'b0});
    end
    any_written = 1'b1;
  endfunction

  // Emission stops for the rest of the text; a text that stops before
  // emitting anything counts as failed.
  function void stop_text();
    text_phase = S_DONE;
    if (!any_written) begin
      text_failed = 1'b1;
    end
  endfunction

  // Walks one character through the grammar. Some phases only decide where
  // the character belongs and hand it on to the next phase in the same step.
  function automatic void advance_grammar(input logic [7:0] c);
    bit again;
    bit digit;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (text_phase)
        S_START: begin
          if (c == CH_MINUS) put_char(c);
          else again = 1'b1;
          text_phase = S_SIGN;
        end
        S_SIGN: begin
          if (c == CH_I) begin
            text_phase = S_I1;
          end else if (c == CH_ZERO) begin
            text_phase = S_ZEROS;
          end else begin
            text_phase = S_DOTQ;
            again = 1'b1;
          end
        end
        S_I1: begin
          if (c == CH_N) begin
            text_phase = S_I2;
          end else begin
            text_failed = 1'b1;
            text_phase = S_DONE;
          end
        end
        S_I2: begin
          if (c == CH_F) begin
            put_char(CH_ONE);
            put_char(CH_E_LO);
            put_char(CH_NINE);
            put_char(CH_NINE);
          end else begin
            text_failed = 1'b1;
          end
          text_phase = S_DONE;
        end
        S_ZEROS: begin
          if (c != CH_ZERO) begin
            text_phase = S_DOTQ;
            again = 1'b1;
          end
        end
        S_DOTQ: begin
          if (c == CH_DOT) begin
            put_char(CH_ZERO);
            put_char(CH_DOT);
            lead_dot = 1'b1;
            text_phase = S_DOT1;
          end else begin
            text_phase = S_INT;
            again = 1'b1;
          end
        end
        S_DOT1: begin
          if (!digit) put_char(CH_ZERO);
          text_phase = S_INT;
          again = 1'b1;
        end
        S_INT: begin
          if (digit) begin
            put_char(c);
          end else if (c == CH_DOT) begin
            if (lead_dot) begin
              stop_text();
            end else begin
              put_char(c);
              text_phase = S_DOT2;
            end
          end else begin
            text_phase = S_ECHK;
            again = 1'b1;
          end
        end
        S_DOT2: begin
          if (digit) begin
            put_char(c);
            text_phase = S_FRAC;
          end else begin
            put_char(CH_ZERO);
            text_phase = S_ECHK;
            again = 1'b1;
          end
        end
        S_FRAC: begin
          if (digit) begin
            put_char(c);
          end else begin
            text_phase = S_ECHK;
            again = 1'b1;
          end
        end
        S_ECHK: begin
          if (c == CH_E_LO || c == CH_E_UP) begin
            put_char(c);
            text_phase = S_AFTER_E;
          end else begin
            stop_text();
          end
        end
        S_AFTER_E: begin
          if (c == CH_MINUS || c == CH_PLUS) put_char(c);
          else again = 1'b1;
          text_phase = S_ESIGN;
        end
        S_ESIGN: begin
          if (digit) begin
            put_char(c);
            text_phase = S_EXP;
          end else begin
            put_char(CH_ZERO);
            stop_text();
          end
        end
        S_EXP: begin
          if (digit) put_char(c);
          else stop_text();
        end
        default: text_phase = S_DONE;
      endcase
    end
  endfunction

  // Results caused by one character land in step_out. On the final character
  // an unfinished number is closed with a '0', the status goes on the last
  // result (or on a status-only result), and the grammar starts over.
  function automatic void predict_char(input logic [7:0] c, input bit last);
    bit          bad;
    nt2j_entry_t tail;
    bad = 1'b0;
    step_out.delete();
    advance_grammar(c);
    if (last) begin
      case (text_phase)
        S_SIGN, S_I1, S_I2: bad = 1'b1;
        S_ZEROS, S_DOT1, S_DOT2, S_AFTER_E, S_ESIGN: put_char(CH_ZERO);
        default: ;
      endcase
      if (text_failed || !any_written) bad = 1'b1;
      if (step_out.size() == 0) begin
        step_out.push_back('{out_char: 8'h00, has_char: 1'b0, end_of_text: 1'b1,
                             failed: bad});
      end else begin
        tail = step_out[step_out.size() - 1];
        tail.end_of_text = 1'b1;
        tail.failed = bad;
        step_out[step_out.size() - 1] = tail;
      end
      text_phase  = S_START;
      lead_dot    = 1'b0;
      text_failed = 1'b0;
      any_written = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one character and waits for the request to be taken. The valid
  // stays high into the next character when no gap is drawn.
  task automatic send_char(input logic [7:0] c, input bit last, input bit use_prediction);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // Characters after the grammar has stopped are only swallowed.
    if (text_phase != S_DONE) live_chars++;
    predict_char(c, last);
    if (use_prediction) begin
      foreach (step_out[j]) expected_q.push_back(step_out[j]);
    end
  endtask

  task automatic send_text(input bit use_prediction);
    int n;
    n = text_q.size();
    for (int k = 0; k < n; k++) begin
      send_char(text_q[k], k == n - 1, use_prediction);
    end
  endtask

  // Typed expectation of a whole text: its characters, then the status either
  // on the last character or on a separate status-only result.
  task automatic push_typed(input string want, input bit want_fail, input bit status_tail);
    nt2j_entry_t e;
    for (int k = 0; k < want.len(); k++) begin
      e = '{out_char: want[k], has_char: 1'b1, end_of_text: 1'b0, failed: 1'b0};
      if (!status_tail && k == want.len() - 1) begin
        e.end_of_text = 1'b1;
        e.failed = want_fail;
      end
      expected_q.push_back(e);
    end
    if (status_tail || want.len() == 0) begin
      expected_q.push_back('{out_char: 8'h00, has_char: 1'b0, end_of_text: 1'b1,
                             failed: want_fail});
    end
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Builds one random text. Most are well-formed numbers; the rest are
  // byte noise, inf words (sometimes broken), cut-short numbers, and numbers
  // with a stray character after them.
  task automatic make_random_text();
    int unsigned kind;
    int unsigned n;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      if ($urandom_range(0, 1) == 1) text_q.push_back(CH_MINUS);
      text_q.push_back(CH_I);
      text_q.push_back(CH_N);
      text_q.push_back(CH_F);
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(text_q.size() - 3, text_q.size() - 1);
        text_q[n] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, text_q.size());
        while (text_q.size() > n) void'(text_q.pop_back());
      end
      if ($urandom_range(0, 2) == 0) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
      repeat ($urandom_range(0, 2)) text_q.push_back(CH_ZERO);
      repeat ($urandom_range(0, 4)) text_q.push_back(rand_digit());
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
        text_q.push_back(($urandom_range(0, 1) == 1) ? CH_E_UP : CH_E_LO);
        n = $urandom_range(0, 2);
        if (n == 1) text_q.push_back(CH_PLUS);
        else if (n == 2) text_q.push_back(CH_MINUS);
        repeat ($urandom_range(0, 2)) text_q.push_back(rand_digit());
      end
      if (kind == 2 && text_q.size() > 1) begin
        n = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > n) void'(text_q.pop_back());
      end
      if (kind == 3) begin
        case ($urandom_range(0, 3))
          0: text_q.push_back(CH_DOT);
          1: text_q.push_back(CH_E_LO);
          2: text_q.push_back(CH_PLUS);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    if (text_q.size() == 0) text_q.push_back(rand_digit());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random texts until enough
  // characters have reached the grammar.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] ch;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_texts[r]) begin
      text_q.delete();
      for (int k = 0; k < directed_texts[r].text.len(); k++) begin
        ch = directed_texts[r].text[k];
        if (ch == "#") ch = BYTE_NUL;
        else if (ch == "~") ch = BYTE_TOP;
        text_q.push_back(ch);
      end
      if (directed_texts[r].typed) begin
        push_typed(directed_texts[r].want, directed_texts[r].want_fail,
                   directed_texts[r].status_tail);
      end
      send_text(!directed_texts[r].typed);
    end

    while (live_chars < TOTAL_CHARS) begin
      // Idle gaps come and go in stretches so that runs at full rate occur.
      if ($urandom_range(0, 15) == 0) send_idle = !send_idle;
      make_random_text();
      send_text(1'b1);
    end
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    // Keep running for DRAIN_CYCLES so that any stray result still shows up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random ready gaps per result, and one long hold-off early
  // in the run so that the burst buffer fills and the input request stalls.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          sink_idle;
    taken = 0;
    sink_idle = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 40) == 0) sink_idle = !sink_idle;
      gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    nt2j_entry_t got;
    nt2j_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_char: out_tdata, has_char: out_tuser[0], end_of_text: out_tlast,
              failed: out_tuser[1]};
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result char %02h has %0b end %0b fail %0b",
                                  got.out_char, got.has_char, got.end_of_text, got.failed));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "got char %02h has %0b end %0b fail %0b, want char %02h has %0b end %0b fail %0b",
            got.out_char, got.has_char, got.end_of_text, got.failed,
            want.out_char, want.has_char, want.end_of_text, want.failed));
        end
      end
    end
  end

  // Ends a run that hangs with a failure message.
  initial begin : watchdog
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
